// ----- design/dafd_pkg.sv -----
package dafd_pkg;

  localparam int unsigned SAMPLES_PER_FRAME = 14;
  localparam int unsigned NUM_COEF_PAIRS    = 8;
  localparam int unsigned COEF_IDX_W        = $clog2(NUM_COEF_PAIRS);
  localparam int unsigned CFG_IDX_W         = 4;
  localparam int unsigned CFG_DATA_W        = 32;
  localparam int unsigned SAMPLE_IDX_W      = 4;
  localparam int unsigned PCM_W             = 16;
  localparam int unsigned FRAC_BITS         = 11;
  localparam int unsigned ACC_W             = 34;
  localparam logic signed [ACC_W-1:0] ROUND_BIAS = 34'sd1024;
  localparam logic signed [ACC_W-1:0] PCM_MAX    = 34'sd32767;
  localparam logic signed [ACC_W-1:0] PCM_MIN    = -34'sd32768;

  // controller -> datapath
  typedef struct packed {
    logic                    load;  // input request accepted
    logic                    step;  // decode one sample into the output register
    logic                    last;  // sample being decoded closes the frame
    logic [SAMPLE_IDX_W-1:0] idx;   // position of that sample
  } cmd_t;

endpackage

// ----- design/dafd_ctrl.sv -----
module dafd_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [dafd_pkg::SAMPLE_IDX_W-1:0]   sample_count_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output dafd_pkg::cmd_t                      cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e                            state_q;
  logic                              out_valid_q;
  logic [dafd_pkg::SAMPLE_IDX_W-1:0] idx_q;
  logic [dafd_pkg::SAMPLE_IDX_W-1:0] last_idx_q;
  logic [dafd_pkg::SAMPLE_IDX_W-1:0] count_clamped;
  logic                              accept;
  logic                              step;
  logic                              last;

  always_comb begin
    if (sample_count_i > dafd_pkg::SAMPLE_IDX_W'(dafd_pkg::SAMPLES_PER_FRAME)) begin
      count_clamped = dafd_pkg::SAMPLE_IDX_W'(dafd_pkg::SAMPLES_PER_FRAME);
    end else begin
      count_clamped = sample_count_i;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  // output slot is free or being emptied this cycle
  assign step       = (state_q == ST_RUN) && (!out_valid_q || out_ready_i);
  assign last       = (idx_q == last_idx_q);

  assign out_valid_o = out_valid_q;
  assign cmd_o.load  = accept;
  assign cmd_o.step  = step;
  assign cmd_o.last  = last;
  assign cmd_o.idx   = idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      last_idx_q  <= '0;
    end else begin
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept && (count_clamped != '0)) begin
            state_q    <= ST_RUN;
            idx_q      <= '0;
            last_idx_q <= count_clamped - 1'b1;
          end
        end
        ST_RUN: begin
          if (step) begin
            if (last) begin
              state_q <= ST_IDLE;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- design/dafd_datapath.sv -----
module dafd_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [dafd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [dafd_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  dafd_pkg::cmd_t                      cmd_i,
  input  logic [63:0]                         frame_bytes_i,
  input  logic                                load_history_i,
  input  logic signed [15:0]                  history_newest_i,
  input  logic signed [15:0]                  history_older_i,
  output logic signed [15:0]                  pcm_sample_o,
  output logic [dafd_pkg::SAMPLE_IDX_W-1:0]   sample_index_o,
  output logic                                last_of_frame_o
);

  localparam int unsigned AccW = dafd_pkg::ACC_W;

  logic [dafd_pkg::CFG_DATA_W-1:0]   coef_q [dafd_pkg::NUM_COEF_PAIRS];
  logic [dafd_pkg::CFG_DATA_W-1:0]   coef_sel;
  logic [55:0]                       nib_q;
  logic [3:0]                        shift_q;
  logic signed [15:0]                c1_q, c2_q;
  logic signed [15:0]                hist1_q, hist2_q;
  logic signed [15:0]                pcm_q;
  logic [dafd_pkg::SAMPLE_IDX_W-1:0] idx_q;
  logic                              last_q;

  logic signed [3:0]      nib;
  logic signed [AccW-1:0] nib_term;
  logic signed [31:0]     prod1, prod2;
  logic signed [AccW-1:0] acc;
  logic signed [AccW-1:0] acc_sh;
  logic signed [15:0]     smp;

  // coefficient register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < dafd_pkg::NUM_COEF_PAIRS; i++) begin
        coef_q[i] <= '0;
      end
    end else if (cfg_we_i &&
                 (cfg_index_i < dafd_pkg::CFG_IDX_W'(dafd_pkg::NUM_COEF_PAIRS))) begin
      coef_q[cfg_index_i[dafd_pkg::COEF_IDX_W-1:0]] <= cfg_data_i;
    end
  end

  // predictor index: low 3 bits of the header's upper nibble
  assign coef_sel = coef_q[frame_bytes_i[60 +: dafd_pkg::COEF_IDX_W]];

  // per-sample arithmetic
  assign nib      = signed'(nib_q[55:52]);
  assign nib_term = AccW'(nib) <<< (5'(shift_q) + 5'(dafd_pkg::FRAC_BITS));
  assign prod1    = c1_q * hist1_q;
  assign prod2    = c2_q * hist2_q;
  assign acc      = nib_term + dafd_pkg::ROUND_BIAS + AccW'(prod1) + AccW'(prod2);
  assign acc_sh   = acc >>> dafd_pkg::FRAC_BITS;

  always_comb begin
    priority if (acc_sh > dafd_pkg::PCM_MAX) begin
      smp = 16'sh7fff;
    end else if (acc_sh < dafd_pkg::PCM_MIN) begin
      smp = -16'sh8000;
    end else begin
      smp = acc_sh[15:0];
    end
  end

  // history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist1_q <= '0;
      hist2_q <= '0;
    end else if (cmd_i.load && load_history_i) begin
      hist1_q <= history_newest_i;
      hist2_q <= history_older_i;
    end else if (cmd_i.step) begin
      hist1_q <= smp;
      hist2_q <= hist1_q;
    end
  end

  // frame and output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      nib_q   <= frame_bytes_i[55:0];
      shift_q <= frame_bytes_i[59:56];
      c1_q    <= signed'(coef_sel[31:16]);
      c2_q    <= signed'(coef_sel[15:0]);
    end else if (cmd_i.step) begin
      nib_q <= {nib_q[51:0], 4'h0};
    end
    if (cmd_i.step) begin
      pcm_q  <= smp;
      idx_q  <= cmd_i.idx;
      last_q <= cmd_i.last;
    end
  end

  assign pcm_sample_o    = pcm_q;
  assign sample_index_o  = idx_q;
  assign last_of_frame_o = last_q;

endmodule

// ----- design/dsp_adpcm_frame_decoder_core.sv -----
// ADPCM frame decoder core.
// Input channel (in_valid_i/in_ready_o) takes one 8-byte frame per request with
// its sample count and an optional history preload. Output channel
// (out_valid_o/out_ready_i) returns one request per decoded sample, with its
// index in the frame and a last flag on the final one; a count of zero gives none.
// Predictor pairs are loaded through cfg_we_i/cfg_index_i/cfg_data_i only while
// idle; the user must ensure it, the block does not. Indexes 8 and up are dropped.
// Timing: a frame is taken while idle; the controller then enters its run state
// and each step writes one sample into the output register, one sample per cycle
// while the receiver does not stall. The rate is set by
// the history recurrence: two 16x16 multiplies, an add and a saturate per cycle.
// The next frame is taken once the last sample has been computed, even while
// that sample still waits in the output register.
// When the receiver stalls, decoding halts with the pending sample held.
// Reset clears the coefficients, the history and all handshake state.
module dsp_adpcm_frame_decoder_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [dafd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [dafd_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [63:0]                         frame_bytes_i,
  input  logic [dafd_pkg::SAMPLE_IDX_W-1:0]   sample_count_i,
  input  logic                                load_history_i,
  input  logic signed [15:0]                  history_newest_i,
  input  logic signed [15:0]                  history_older_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [15:0]                  pcm_sample_o,
  output logic [dafd_pkg::SAMPLE_IDX_W-1:0]   sample_index_o,
  output logic                                last_of_frame_o
);

  dafd_pkg::cmd_t cmd;

  dafd_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_count_i (sample_count_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .cmd_o          (cmd)
  );

  dafd_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .cmd_i            (cmd),
    .frame_bytes_i    (frame_bytes_i),
    .load_history_i   (load_history_i),
    .history_newest_i (history_newest_i),
    .history_older_i  (history_older_i),
    .pcm_sample_o     (pcm_sample_o),
    .sample_index_o   (sample_index_o),
    .last_of_frame_o  (last_of_frame_o)
  );

endmodule
